// File: sv/hrsad_pkg.sv
// ----------------------------------------------------------------------------
// hrsad_pkg - shared types and constants
// colors, pixel cell type and the ink/paper state bundle for the decoder
// ----------------------------------------------------------------------------
`default_nettype none

package hrsad_pkg;

  localparam int unsigned NumPixels  = 6;
  localparam int unsigned ColorW     = 3;

  typedef logic [ColorW-1:0] color_t;

  // reset colors, also restored at every line start
  localparam color_t InkReset   = 3'd7;
  localparam color_t PaperReset = 3'd0;

  // bits 6..3 of an attribute byte
  localparam logic [3:0] AttrInkHi   = 4'b0000;
  localparam logic [3:0] AttrPaperHi = 4'b0010;

  // pixel_0 is element 0 (leftmost)
  typedef color_t [NumPixels-1:0] pixel_row_t;

  typedef struct packed {
    color_t ink;
    color_t paper;
  } color_state_t;

endpackage : hrsad_pkg

`default_nettype wire

// File: sv/hrsad_cell_decode.sv
// ----------------------------------------------------------------------------
// hrsad_cell_decode - one screen byte to six pixels
// applies line-start reset and attribute updates, then draws the cell
// ----------------------------------------------------------------------------
`default_nettype none

module hrsad_cell_decode (
  input  wire logic [7:0]              screen_byte,
  input  wire logic                    line_start,
  input  wire hrsad_pkg::color_state_t cur_state,
  output hrsad_pkg::color_state_t      nxt_state,
  output hrsad_pkg::pixel_row_t        pixels
);

  logic [6:0]        low7;
  logic              is_ink_attr;
  logic              is_paper_attr;
  logic [5:0]        pattern;
  hrsad_pkg::color_t base_ink;
  hrsad_pkg::color_t base_paper;
  hrsad_pkg::color_t draw_ink;
  hrsad_pkg::color_t draw_paper;

  assign low7          = screen_byte[6:0];
  assign is_ink_attr   = (low7[6:3] == hrsad_pkg::AttrInkHi);
  assign is_paper_attr = (low7[6:3] == hrsad_pkg::AttrPaperHi);

  always_comb begin
    base_ink   = line_start ? hrsad_pkg::InkReset   : cur_state.ink;
    base_paper = line_start ? hrsad_pkg::PaperReset : cur_state.paper;

    nxt_state.ink   = is_ink_attr   ? low7[2:0] : base_ink;
    nxt_state.paper = is_paper_attr ? low7[2:0] : base_paper;

    pattern = (is_ink_attr || is_paper_attr) ? 6'd0 : low7[5:0];

    // inverse: 7 - c is the bitwise complement for 3-bit colors
    draw_ink   = screen_byte[7] ? ~nxt_state.ink   : nxt_state.ink;
    draw_paper = screen_byte[7] ? ~nxt_state.paper : nxt_state.paper;

    for (int i = 0; i < hrsad_pkg::NumPixels; i++) begin
      pixels[i] = pattern[hrsad_pkg::NumPixels-1-i] ? draw_ink : draw_paper;
    end
  end

endmodule : hrsad_cell_decode

`default_nettype wire

// File: sv/hires_serial_attribute_decoder.sv
// ----------------------------------------------------------------------------
// hires_serial_attribute_decoder - serial-attribute hires cell decoder
// result: registered, in the output register the cycle after the input beat is accepted
// throughput: one beat per cycle unless the receiver stalls; input stays ready while the result is taken
// rate set by the single decode pass between color state and output register
// reset: synchronous active-low; ink goes to white, paper to black, output empty
// ----------------------------------------------------------------------------
`default_nettype none

module hires_serial_attribute_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] screen_byte
  input  wire logic [0:0]  in_tuser,   // [0] line_start
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata   // [2:0] pixel_0 .. [17:15] pixel_5, [23:18] zero
);

  logic                    in_fire;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  hrsad_pkg::pixel_row_t   out_pix_r;
  hrsad_pkg::pixel_row_t   out_pix_nxt;
  hrsad_pkg::color_state_t colors_r;
  hrsad_pkg::color_state_t colors_nxt;

  // the output register frees up in the same cycle its beat is taken
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  hrsad_cell_decode u_decode (
    .screen_byte (in_tdata),
    .line_start  (in_tuser[0]),
    .cur_state   (colors_r),
    .nxt_state   (colors_nxt),
    .pixels      (out_pix_nxt)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control state and colors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      colors_r.ink   <= hrsad_pkg::InkReset;
      colors_r.paper <= hrsad_pkg::PaperReset;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_fire) begin
        colors_r <= colors_nxt;
      end
    end
  end

  // result payload, loaded only on an accepted beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_pix_r <= out_pix_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_pix_r};

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // an accepted beat always shows up in the output register
  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("accepted beat produced no result");

  // attribute cells draw six identical pixels
  a_attr_uniform: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && (in_tdata[6:3] == hrsad_pkg::AttrInkHi ||
                 in_tdata[6:3] == hrsad_pkg::AttrPaperHi))
    |=> (out_tdata[2:0] == out_tdata[5:3]) && (out_tdata[2:0] == out_tdata[8:6]) &&
        (out_tdata[2:0] == out_tdata[11:9]) && (out_tdata[2:0] == out_tdata[14:12]) &&
        (out_tdata[2:0] == out_tdata[17:15]))
    else $error("attribute cell not drawn in a single color");

  // pixel data right after a line start uses white ink on black paper
  a_line_start_colors: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tuser[0] && !in_tdata[7] && in_tdata[6:5] != 2'b00)
    |=> out_tdata[2:0] == ($past(in_tdata[5]) ? hrsad_pkg::InkReset
                                               : hrsad_pkg::PaperReset))
    else $error("line start did not restore default colors");

endmodule : hires_serial_attribute_decoder

`default_nettype wire

// File: test/tb_hires_serial_attribute_decoder.sv
// ----------------------------------------------------------------------------
// tb_hires_serial_attribute_decoder - self-checking bench for the hires decoder
// drives screen bytes with line starts through the input stream, predicts the
// six-pixel cell of every beat and compares each result beat field by field
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hires_serial_attribute_decoder;

  localparam int unsigned WatchLimit = 1000;  // quiet cycles before giving up
  localparam int unsigned NumRows    = 23;
  localparam int unsigned RandCells  = 600;

  // directed row: screen byte, line start, typed flag, uniform fill color
  typedef struct packed {
    logic [7:0]        sbyte;
    logic              ls;
    logic              typed;
    hrsad_pkg::color_t fill;
  } cell_row_t;

  // typed rows only where every pixel is one obvious color
  localparam logic [12:0] CellTable [NumRows] = '{
    {8'h3F, 1'b0, 1'b1, 3'd7},  // after reset: full pattern in white ink
    {8'h00, 1'b0, 1'b1, 3'd0},  // ink black, cell is black paper
    {8'h10, 1'b0, 1'b1, 3'd0},  // paper black
    {8'h17, 1'b0, 1'b1, 3'd7},  // paper white, cell all white
    {8'h2A, 1'b0, 1'b0, 3'd0},  // alternating pattern, ink black on white
    {8'h07, 1'b1, 1'b1, 3'd0},  // line start then ink attr: paper back to black
    {8'h87, 1'b0, 1'b1, 3'd7},  // inverse ink attr: inverted black paper
    {8'h7F, 1'b0, 1'b0, 3'd0},  // low seven bits at max, bit 6 ignored
    {8'hFF, 1'b0, 1'b0, 3'd0},  // all ones byte
    {8'h08, 1'b0, 1'b0, 3'd0},  // just above ink range is pixel data
    {8'h0F, 1'b0, 1'b0, 3'd0},  // top of the gap between attr ranges
    {8'h18, 1'b0, 1'b0, 3'd0},  // just above paper range is pixel data
    {8'h40, 1'b0, 1'b0, 3'd0},  // bit 6 alone, empty pattern
    {8'h80, 1'b1, 1'b1, 3'd7},  // line start, inverse black ink attr
    {8'h90, 1'b0, 1'b0, 3'd0},  // inverse paper attr, low end
    {8'h97, 1'b0, 1'b0, 3'd0},  // inverse paper attr, high end
    {8'h14, 1'b1, 1'b0, 3'd0},  // line start with paper attr in first byte
    {8'h03, 1'b0, 1'b0, 3'd0},  // ink attr mid range
    {8'h55, 1'b0, 1'b0, 3'd0},  // pattern 010101
    {8'hD5, 1'b0, 1'b0, 3'd0},  // same pattern inverted
    {8'h1F, 1'b0, 1'b0, 3'd0},  // pixel data above the paper range
    {8'h01, 1'b1, 1'b0, 3'd0},  // line start and ink attr
    {8'h3F, 1'b1, 1'b1, 3'd7}   // line start restores white ink
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;  // [7:0] screen_byte
  logic [0:0]  in_tuser   = '0;  // [0] line_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // [2:0] pixel_0 .. [17:15] pixel_5, [23:18] zero

  // expected cell for the beat on the input, when typed by hand
  logic              row_typed  = 1'b0;
  hrsad_pkg::color_t row_fill   = '0;

  hrsad_pkg::color_state_t colors;          // predicted ink/paper state
  hrsad_pkg::pixel_row_t   pixels_due[$];   // expected cells in arrival order

  int unsigned cells_taken  = 0;
  int unsigned cells_seen   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned fails        = 0;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;

  // coverage tallies for the summary
  int unsigned ink_cells = 0, paper_cells = 0, pattern_cells = 0;
  int unsigned inverse_cells = 0, line_starts = 0;

  hires_serial_attribute_decoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // predicted cell for one screen byte; updates the color state
  function automatic hrsad_pkg::pixel_row_t decode_cell(input logic [7:0] sbyte,
                                                        input logic ls);
    logic [6:0]            low;
    logic [5:0]            pat;
    hrsad_pkg::color_t     ink;
    hrsad_pkg::color_t     paper;
    hrsad_pkg::pixel_row_t row;
    low = sbyte[6:0];
    pat = '0;
    if (ls) begin
      colors.ink   = hrsad_pkg::InkReset;
      colors.paper = hrsad_pkg::PaperReset;
    end
    // attribute cells draw as plain paper, everything else is a pattern
    if (low[6:3] == hrsad_pkg::AttrInkHi) begin
      colors.ink = low[2:0];
    end else if (low[6:3] == hrsad_pkg::AttrPaperHi) begin
      colors.paper = low[2:0];
    end else begin
      pat = low[5:0];
    end
    ink   = colors.ink;
    paper = colors.paper;
    // inverse only affects this cell, not the stored colors
    if (sbyte[7]) begin
      ink   = 3'd7 - ink;
      paper = 3'd7 - paper;
    end
    // bit 5 is the leftmost pixel
    for (int i = 0; i < hrsad_pkg::NumPixels; i++) begin
      row[i] = pat[5-i] ? ink : paper;
    end
    return row;
  endfunction

  // monitor: both handshakes are sampled at the rising edge
  always @(posedge clk) begin : mon
    hrsad_pkg::pixel_row_t pred;
    hrsad_pkg::pixel_row_t want;
    logic [2:0]            got;
    if (rst_n) begin
      // push first so a same-edge result still finds its expectation
      if (in_tvalid && in_tready) begin
        pred = decode_cell(in_tdata, in_tuser[0]);
        pixels_due.push_back(row_typed ? {hrsad_pkg::NumPixels{row_fill}} : pred);
        cells_taken++;
        if (in_tdata[6:3] == hrsad_pkg::AttrInkHi) ink_cells++;
        else if (in_tdata[6:3] == hrsad_pkg::AttrPaperHi) paper_cells++;
        else pattern_cells++;
        if (in_tdata[7]) inverse_cells++;
        if (in_tuser[0]) line_starts++;
      end
      if (out_tvalid && out_tready) begin
        cells_seen++;
        if (pixels_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual %h",
                   $time, out_tdata);
          fails++;
        end else begin
          want = pixels_due.pop_front();
          for (int i = 0; i < hrsad_pkg::NumPixels; i++) begin
            got = out_tdata[3*i +: 3];
            if (got !== want[i]) begin
              $display("%0t: pixel_%0d mismatch, expected %0d, actual %0d",
                       $time, i, want[i], got);
              fails++;
            end
          end
          if (out_tdata[23:18] !== 6'd0) begin
            $display("%0t: pad bits mismatch, expected 0, actual %h",
                     $time, out_tdata[23:18]);
            fails++;
          end
        end
      end
      // watchdog feed: any beat on either side counts as progress
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
  end

  // hand one beat to the decoder and hold it until taken
  task automatic send_cell(input logic [7:0] sbyte, input logic ls,
                           input logic typed, input hrsad_pkg::color_t fill);
    int unsigned target;
    // sender idle cycles between beats
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    target = cells_taken + 1;
    in_tdata  <= sbyte;
    in_tuser  <= ls;
    row_typed <= typed;
    row_fill  <= fill;
    in_tvalid <= 1'b1;
    do @(negedge clk); while (cells_taken < target);
  endtask

  // hold off the sender until every cell has come back
  task automatic drain_cells;
    in_tvalid <= 1'b0;
    while (pixels_due.size() != 0) @(negedge clk);
  endtask

  // line-structured random bytes, biased toward attribute cells
  task automatic send_random_lines(input int unsigned count);
    int unsigned line_left;
    int unsigned pick;
    logic [7:0]  sbyte;
    logic        ls;
    line_left = 0;
    for (int unsigned n = 0; n < count; n++) begin
      ls = 1'b0;
      if (line_left == 0) begin
        ls = 1'b1;
        line_left = $urandom_range(1, 40);
      end
      line_left--;
      // stray line starts in the middle of a line
      if ($urandom_range(0, 99) < 4) ls = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 25) sbyte = {1'($urandom), hrsad_pkg::AttrInkHi, 3'($urandom)};
      else if (pick < 45) sbyte = {1'($urandom), hrsad_pkg::AttrPaperHi, 3'($urandom)};
      else sbyte = 8'($urandom_range(0, 255));
      send_cell(sbyte, ls, 1'b0, 3'd0);
    end
  endtask

  // timeout: too long without any beat on either side
  initial begin
    while (quiet_cycles < WatchLimit) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $time, WatchLimit);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stim
    cell_row_t row;
    colors.ink   = hrsad_pkg::InkReset;
    colors.paper = hrsad_pkg::PaperReset;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table, sender idling lightly and receiver heavily
    snd_idle_pct = 10;
    rcv_idle_pct = 66;
    for (int r = 0; r < NumRows; r++) begin
      row = cell_row_t'(CellTable[r]);
      send_cell(row.sbyte, row.ls, row.typed, row.fill);
    end
    drain_cells();

    send_random_lines(RandCells / 3);
    drain_cells();

    // roles swapped: sender mostly idle, receiver nearly always ready
    snd_idle_pct = 66;
    rcv_idle_pct = 10;
    send_random_lines(RandCells / 3);
    drain_cells();

    // full rate on both sides
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    send_random_lines(RandCells / 3);
    drain_cells();

    // final check that no expected cell is still outstanding
    repeat (4) @(negedge clk);
    if (pixels_due.size() != 0) begin
      $display("%0t: %0d expected cells never arrived", $time, pixels_due.size());
      fails++;
    end

    $display("covered %0d beats: %0d ink attrs, %0d paper attrs, %0d pattern cells",
             cells_taken, ink_cells, paper_cells, pattern_cells);
    $display("%0d inverse cells, %0d line starts, %0d results checked, %0d errors",
             inverse_cells, line_starts, cells_seen, fails);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : tb_hires_serial_attribute_decoder

`default_nettype wire

// File: filelist.f
sv/hrsad_pkg.sv
sv/hrsad_cell_decode.sv
sv/hires_serial_attribute_decoder.sv
test/tb_hires_serial_attribute_decoder.sv
